// ----- rtl/xtea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

    localparam int WORD_W  = 32;
    localparam int ROUND_W = 8;
    localparam int KEY_N   = 4;
    localparam int KEY_SEL_W = 2;
    localparam int KEY_SHIFT = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0]  STD_DELTA  = 32'h9E37_79B9;
    localparam logic [ROUND_W-1:0] STD_ROUNDS = 8'd32;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_DELTA  = 3'd4,
        REG_ROUNDS = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [KEY_N-1:0][WORD_W-1:0] key;
        logic [WORD_W-1:0]            delta;
        logic [ROUND_W-1:0]           rounds;
    } cfg_t;

    typedef struct packed {
        logic decrypt;
        logic key_hi;
    } hr_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/xtea_block_cipher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A block is taken only in idle and runs R rounds, R = effective round count (default 32).
// One half-round per cycle through a single shared mix/add unit, the first half updating
// the round sum; the final half-round holds while the output register is still full.
// A finished block waits in the output register while the next one is taken.
// Reset: synchronous active-low aresetn clears control and restores default registers.

module xtea_block_cipher (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [xtea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]        cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_opcode,
    input  wire logic [xtea_pkg::WORD_W-1:0]        s_first_word_in,
    input  wire logic [xtea_pkg::WORD_W-1:0]        s_second_word_in,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [xtea_pkg::WORD_W-1:0]             m_first_word_out,
    output logic [xtea_pkg::WORD_W-1:0]             m_second_word_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    localparam int PROD_W = xtea_pkg::WORD_W + xtea_pkg::ROUND_W;

    xtea_pkg::cfg_t     cfg;
    xtea_pkg::hr_ctrl_t hr_ctrl;

    state_t                        state_reg, state_next;
    logic                          phase_reg, phase_next;
    logic                          dec_reg, dec_next;
    logic [xtea_pkg::ROUND_W-1:0]  rnd_reg, rnd_next;
    logic [xtea_pkg::WORD_W-1:0]   v0_reg, v0_next;
    logic [xtea_pkg::WORD_W-1:0]   v1_reg, v1_next;
    logic [xtea_pkg::WORD_W-1:0]   sum_reg, sum_next;
    logic                          m_valid_reg, m_valid_next;
    logic [xtea_pkg::WORD_W-1:0]   out0_reg, out0_next;
    logic [xtea_pkg::WORD_W-1:0]   out1_reg, out1_next;

    logic [PROD_W-1:0]             dec_sum_prod;
    logic                          writes_v0;
    logic                          last_step;
    logic                          out_free;
    logic [xtea_pkg::WORD_W-1:0]   hr_src;
    logic [xtea_pkg::WORD_W-1:0]   hr_dst;
    logic [xtea_pkg::WORD_W-1:0]   hr_result;

    xtea_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // first half of a round writes v0 on encrypt, v1 on decrypt
    assign writes_v0       = ~(phase_reg ^ dec_reg);
    assign hr_ctrl.decrypt = dec_reg;
    assign hr_ctrl.key_hi  = phase_reg ^ dec_reg;
    assign hr_src          = writes_v0 ? v1_reg : v0_reg;
    assign hr_dst          = writes_v0 ? v0_reg : v1_reg;

    xtea_half_round u_half_round (
        .src_word (hr_src),
        .dst_word (hr_dst),
        .sum      (sum_reg),
        .key      (cfg.key),
        .ctrl     (hr_ctrl),
        .result   (hr_result)
    );

    assign dec_sum_prod = cfg.delta * cfg.rounds;
    assign last_step    = (state_reg == ST_RUN) && phase_reg
                          && (rnd_reg == xtea_pkg::ROUND_W'(1));
    assign out_free     = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        dec_next     = dec_reg;
        rnd_next     = rnd_reg;
        v0_next      = v0_reg;
        v1_next      = v1_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out0_next    = out0_reg;
        out1_next    = out1_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dec_next   = (s_opcode == xtea_pkg::OP_DECRYPT);
                    v0_next    = s_first_word_in;
                    v1_next    = s_second_word_in;
                    sum_next   = (s_opcode == xtea_pkg::OP_DECRYPT)
                                 ? dec_sum_prod[xtea_pkg::WORD_W-1:0] : '0;
                    rnd_next   = cfg.rounds;
                    phase_next = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_step) begin
                    // hold on the final half-round until the output register frees
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        out0_next    = writes_v0 ? hr_result : v0_reg;
                        out1_next    = writes_v0 ? v1_reg : hr_result;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    if (writes_v0) begin
                        v0_next = hr_result;
                    end else begin
                        v1_next = hr_result;
                    end
                    if (!phase_reg) begin
                        sum_next = dec_reg ? (sum_reg - cfg.delta) : (sum_reg + cfg.delta);
                    end else begin
                        rnd_next = rnd_reg - xtea_pkg::ROUND_W'(1);
                    end
                    phase_next = !phase_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dec_reg  <= dec_next;
        rnd_reg  <= rnd_next;
        v0_reg   <= v0_next;
        v1_reg   <= v1_next;
        sum_reg  <= sum_next;
        out0_reg <= out0_next;
        out1_reg <= out1_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_first_word_out  = out0_reg;
    assign m_second_word_out = out1_reg;

    a_rnd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (rnd_reg != '0))
        else $error("round counter reached zero while running");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ((state_reg == ST_RUN) && !phase_reg))
        else $error("accepted word did not start a round");

    a_load_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(last_step))
        else $error("output loaded outside the final half-round");

endmodule

`default_nettype wire

// ----- rtl/xtea_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xtea_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [xtea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]        cfg_wdata,
    output xtea_pkg::cfg_t                          cfg
);

    logic [xtea_pkg::KEY_N-1:0][xtea_pkg::WORD_W-1:0] key_reg;
    logic [xtea_pkg::WORD_W-1:0]                      delta_reg;
    logic [xtea_pkg::ROUND_W-1:0]                     rounds_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg    <= '0;
            delta_reg  <= xtea_pkg::STD_DELTA;
            rounds_reg <= xtea_pkg::STD_ROUNDS;
        end else if (cfg_wr_en) begin
            case (cfg_index) inside
                xtea_pkg::REG_KEY0, xtea_pkg::REG_KEY1,
                xtea_pkg::REG_KEY2, xtea_pkg::REG_KEY3: begin
                    key_reg[cfg_index[xtea_pkg::KEY_SEL_W-1:0]] <= cfg_wdata;
                end
                xtea_pkg::REG_DELTA: begin
                    delta_reg <= cfg_wdata;
                end
                xtea_pkg::REG_ROUNDS: begin
                    rounds_reg <= cfg_wdata[xtea_pkg::ROUND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a zero delta or round count selects the standard value
    always_comb begin
        cfg.key    = key_reg;
        cfg.delta  = (delta_reg == '0) ? xtea_pkg::STD_DELTA : delta_reg;
        cfg.rounds = (rounds_reg == '0) ? xtea_pkg::STD_ROUNDS : rounds_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/xtea_half_round.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xtea_half_round (
    input  wire logic [xtea_pkg::WORD_W-1:0]                      src_word,
    input  wire logic [xtea_pkg::WORD_W-1:0]                      dst_word,
    input  wire logic [xtea_pkg::WORD_W-1:0]                      sum,
    input  wire logic [xtea_pkg::KEY_N-1:0][xtea_pkg::WORD_W-1:0] key,
    input  wire xtea_pkg::hr_ctrl_t                               ctrl,
    output logic [xtea_pkg::WORD_W-1:0]                           result
);

    logic [xtea_pkg::KEY_SEL_W-1:0] key_sel;
    logic [xtea_pkg::WORD_W-1:0]    shuffled;
    logic [xtea_pkg::WORD_W-1:0]    keyed;
    logic [xtea_pkg::WORD_W-1:0]    mix;

    always_comb begin
        key_sel  = ctrl.key_hi ? sum[xtea_pkg::KEY_SHIFT +: xtea_pkg::KEY_SEL_W]
                               : sum[xtea_pkg::KEY_SEL_W-1:0];
        shuffled = ((src_word << 4) ^ (src_word >> 5)) + src_word;
        keyed    = sum + key[key_sel];
        mix      = shuffled ^ keyed;
        result   = ctrl.decrypt ? (dst_word - mix) : (dst_word + mix);
    end

endmodule

`default_nettype wire

// ----- tb/xtea_block_cipher_tb.sv -----
`timescale 1ns / 1ps

module xtea_block_cipher_tb;

    localparam logic [xtea_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [xtea_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_BLOCKS = 1200;

    typedef struct {
        logic                        op;
        logic [xtea_pkg::WORD_W-1:0] first;
        logic [xtea_pkg::WORD_W-1:0] second;
    } plain_block_t;

    typedef struct {
        logic [xtea_pkg::WORD_W-1:0] first;
        logic [xtea_pkg::WORD_W-1:0] second;
    } cipher_words_t;

    logic                           aclk             = 1'b0;
    logic                           aresetn          = 1'b0;
    logic                           cfg_wr_en        = 1'b0;
    logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
    logic [xtea_pkg::WORD_W-1:0]    cfg_wdata        = '0;
    logic                           s_valid          = 1'b0;
    logic                           s_opcode         = xtea_pkg::OP_ENCRYPT;
    logic [xtea_pkg::WORD_W-1:0]    s_first_word_in  = '0;
    logic [xtea_pkg::WORD_W-1:0]    s_second_word_in = '0;
    logic                           m_ready          = 1'b0;
    wire                            s_ready;
    wire                            m_valid;
    wire [xtea_pkg::WORD_W-1:0]     m_first_word_out;
    wire [xtea_pkg::WORD_W-1:0]     m_second_word_out;

    logic [xtea_pkg::WORD_W-1:0]  key_shadow [xtea_pkg::KEY_N] = '{default: '0};
    logic [xtea_pkg::WORD_W-1:0]  delta_shadow       = xtea_pkg::STD_DELTA;
    logic [xtea_pkg::ROUND_W-1:0] rounds_shadow      = xtea_pkg::STD_ROUNDS;

    plain_block_t  pending_blocks [$];
    cipher_words_t expected_blocks [$];

    bit steady_flow    = 1'b0;
    int send_gap       = 0;
    int ready_hold     = 0;
    int failures       = 0;
    int encrypt_count  = 0;
    int decrypt_count  = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int settings_count = 0;

    plain_block_t  next_block;
    cipher_words_t want;

    xtea_block_cipher u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_first_word_in   (s_first_word_in),
        .s_second_word_in  (s_second_word_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_first_word_out  (m_first_word_out),
        .m_second_word_out (m_second_word_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [xtea_pkg::WORD_W-1:0] mix_half(
            input logic [xtea_pkg::WORD_W-1:0] v,
            input logic [xtea_pkg::WORD_W-1:0] sum,
            input logic [xtea_pkg::WORD_W-1:0] k);
        return (((v << 4) ^ (v >> 5)) + v) ^ (sum + k);
    endfunction

    function automatic cipher_words_t run_cipher(input plain_block_t blk);
        cipher_words_t                res;
        logic [xtea_pkg::WORD_W-1:0]  v0;
        logic [xtea_pkg::WORD_W-1:0]  v1;
        logic [xtea_pkg::WORD_W-1:0]  delta;
        logic [xtea_pkg::WORD_W-1:0]  sum;
        logic [xtea_pkg::ROUND_W-1:0] rounds;
        v0     = blk.first;
        v1     = blk.second;
        delta  = (delta_shadow == '0) ? xtea_pkg::STD_DELTA : delta_shadow;
        rounds = (rounds_shadow == '0) ? xtea_pkg::STD_ROUNDS : rounds_shadow;
        if (blk.op == xtea_pkg::OP_ENCRYPT) begin
            sum = '0;
            for (int i = 0; i < rounds; i++) begin
                v0  = v0 + mix_half(v1, sum, key_shadow[sum[xtea_pkg::KEY_SEL_W-1:0]]);
                sum = sum + delta;
                v1  = v1 + mix_half(v0, sum,
                                    key_shadow[sum[xtea_pkg::KEY_SHIFT +: xtea_pkg::KEY_SEL_W]]);
            end
        end else begin
            sum = delta * xtea_pkg::WORD_W'(rounds);
            for (int i = 0; i < rounds; i++) begin
                v1  = v1 - mix_half(v0, sum,
                                    key_shadow[sum[xtea_pkg::KEY_SHIFT +: xtea_pkg::KEY_SEL_W]]);
                sum = sum - delta;
                v0  = v0 - mix_half(v1, sum, key_shadow[sum[xtea_pkg::KEY_SEL_W-1:0]]);
            end
        end
        res.first  = v0;
        res.second = v1;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [xtea_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return xtea_pkg::WORD_W'(1) << $urandom_range(0, xtea_pkg::WORD_W - 1);
            3: return ~(xtea_pkg::WORD_W'(1) << $urandom_range(0, xtea_pkg::WORD_W - 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic void note_failure();
        failures++;
    endfunction

    task automatic push_block(input logic op, input logic [xtea_pkg::WORD_W-1:0] w0,
                              input logic [xtea_pkg::WORD_W-1:0] w1);
        plain_block_t blk;
        blk.op     = op;
        blk.first  = w0;
        blk.second = w1;
        pending_blocks.push_back(blk);
    endtask

    // encrypt blocks are sometimes followed by the decrypt of their own ciphertext
    task automatic queue_random(input int count);
        plain_block_t  blk;
        cipher_words_t ct;
        int            n;
        n = 0;
        while (n < count) begin
            blk.op     = $urandom_range(0, 1) ? xtea_pkg::OP_DECRYPT : xtea_pkg::OP_ENCRYPT;
            blk.first  = pick_word();
            blk.second = pick_word();
            pending_blocks.push_back(blk);
            n++;
            if (blk.op == xtea_pkg::OP_ENCRYPT && $urandom_range(0, 3) == 0) begin
                ct = run_cipher(blk);
                push_block(xtea_pkg::OP_DECRYPT, ct.first, ct.second);
                n++;
            end
        end
    endtask

    task automatic write_reg(input logic [xtea_pkg::CFG_IDX_W-1:0] idx,
                             input logic [xtea_pkg::WORD_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            xtea_pkg::REG_KEY0, xtea_pkg::REG_KEY1, xtea_pkg::REG_KEY2, xtea_pkg::REG_KEY3:
                key_shadow[idx[xtea_pkg::KEY_SEL_W-1:0]] = value;
            xtea_pkg::REG_DELTA:  delta_shadow  = value;
            xtea_pkg::REG_ROUNDS: rounds_shadow = value[xtea_pkg::ROUND_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [xtea_pkg::WORD_W-1:0] k0,
                                 input logic [xtea_pkg::WORD_W-1:0] k1,
                                 input logic [xtea_pkg::WORD_W-1:0] k2,
                                 input logic [xtea_pkg::WORD_W-1:0] k3,
                                 input logic [xtea_pkg::WORD_W-1:0] delta,
                                 input logic [xtea_pkg::WORD_W-1:0] rounds_word);
        write_reg(xtea_pkg::REG_KEY0, k0);
        write_reg(xtea_pkg::REG_KEY1, k1);
        write_reg(xtea_pkg::REG_KEY2, k2);
        write_reg(xtea_pkg::REG_KEY3, k3);
        write_reg(xtea_pkg::REG_DELTA, delta);
        write_reg(xtea_pkg::REG_ROUNDS, rounds_word);
        settings_count++;
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_blocks.size() != 0 || s_valid || expected_blocks.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                next_block.op     = s_opcode;
                next_block.first  = s_first_word_in;
                next_block.second = s_second_word_in;
                expected_blocks.push_back(run_cipher(next_block));
                if (s_opcode == xtea_pkg::OP_ENCRYPT)
                    encrypt_count++;
                else
                    decrypt_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_blocks.size() != 0) begin
                    next_block = pending_blocks.pop_front();
                    s_valid          <= 1'b1;
                    s_opcode         <= next_block.op;
                    s_first_word_in  <= next_block.first;
                    s_second_word_in <= next_block.second;
                    send_gap = steady_flow ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_blocks.size() == 0) begin
                    note_failure();
                    if (failures <= MAX_REPORTS)
                        $display("unexpected result word %h %h", m_first_word_out,
                                 m_second_word_out);
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_first_word_out !== want.first ||
                        m_second_word_out !== want.second) begin
                        note_failure();
                        if (failures <= MAX_REPORTS)
                            $display("mismatch: expected %h %h, got %h %h", want.first,
                                     want.second, m_first_word_out, m_second_word_out);
                    end
                end
            end
            if (steady_flow) begin
                m_ready <= 1'b1;
            end else if (ready_hold > 0) begin
                ready_hold--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                ready_hold = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int                           random_done;
        int                           n;
        logic [xtea_pkg::ROUND_W-1:0] rnd;
        logic [xtea_pkg::WORD_W-1:0]  delta_pick;
        logic [xtea_pkg::WORD_W-1:0]  rounds_word;
        logic [xtea_pkg::WORD_W-1:0]  k [xtea_pkg::KEY_N];

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: zero key, standard delta and rounds
        push_block(xtea_pkg::OP_ENCRYPT, '0, '0);
        push_block(xtea_pkg::OP_DECRYPT, '0, '0);
        push_block(xtea_pkg::OP_ENCRYPT, '1, '1);
        push_block(xtea_pkg::OP_DECRYPT, '1, '1);
        push_block(xtea_pkg::OP_ENCRYPT, '0, '1);
        push_block(xtea_pkg::OP_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        push_block(xtea_pkg::OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        wait_drained();

        // zero delta and zero rounds, rounds written with junk in its upper bits
        apply_setting('1, '1, '1, '1, '0, 32'hFFFF_FF00);
        write_reg(IDX_UNMAPPED_LO, $urandom);
        write_reg(IDX_UNMAPPED_HI, '1);
        push_block(xtea_pkg::OP_ENCRYPT, '0, '0);
        push_block(xtea_pkg::OP_DECRYPT, '1, '0);
        push_block(xtea_pkg::OP_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_random(20);
        wait_drained();

        // longest rounds, all-ones delta
        apply_setting('0, '0, '0, '0, '1, 32'h0000_00FF);
        push_block(xtea_pkg::OP_ENCRYPT, '1, '0);
        push_block(xtea_pkg::OP_DECRYPT, '0, '1);
        push_block(xtea_pkg::OP_ENCRYPT, '1, '1);
        queue_random(3);
        wait_drained();

        // single round, delta of one
        apply_setting(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, 32'd1,
                      32'd1);
        push_block(xtea_pkg::OP_ENCRYPT, '0, '1);
        push_block(xtea_pkg::OP_DECRYPT, '1, '0);
        push_block(xtea_pkg::OP_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        push_block(xtea_pkg::OP_DECRYPT, '0, '0);
        queue_random(60);
        wait_drained();

        random_done = 0;
        while (random_done < RANDOM_BLOCKS) begin
            for (int i = 0; i < xtea_pkg::KEY_N; i++)
                k[i] = pick_word();
            case ($urandom_range(0, 5))
                0: delta_pick = '0;
                1: delta_pick = 32'd1;
                2: delta_pick = '1;
                3: delta_pick = xtea_pkg::STD_DELTA;
                default: delta_pick = $urandom;
            endcase
            n = $urandom_range(0, 19);
            if (n < 14)
                rnd = xtea_pkg::ROUND_W'($urandom_range(1, 8));
            else if (n < 18)
                rnd = xtea_pkg::ROUND_W'($urandom_range(9, 40));
            else if (n == 18)
                rnd = '0;
            else
                rnd = xtea_pkg::ROUND_W'($urandom_range(200, 255));
            rounds_word = $urandom;
            rounds_word[xtea_pkg::ROUND_W-1:0] = rnd;
            apply_setting(k[0], k[1], k[2], k[3], delta_pick, rounds_word);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? IDX_UNMAPPED_HI : IDX_UNMAPPED_LO, $urandom);
            steady_flow = ($urandom_range(0, 4) == 0);
            if (rnd >= 200)
                n = 6;
            else if (rnd > 8 || rnd == 0)
                n = 20;
            else
                n = $urandom_range(40, 80);
            queue_random(n);
            random_done += n;
            wait_drained();
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (2 * 256 + 16) @(posedge aclk);
        if (expected_blocks.size() != 0) begin
            note_failure();
            $display("%0d results never arrived", expected_blocks.size());
        end
        $display("%0d blocks sent (%0d encrypt, %0d decrypt) across %0d register settings",
                 encrypt_count + decrypt_count, encrypt_count, decrypt_count, settings_count);
        $display("%0d results checked, %0d register writes, %0d mismatches",
                 results_seen, reg_writes, failures);
        if (failures == 0)
            $display("xtea_block_cipher_tb passed");
        else
            $display("xtea_block_cipher_tb failed");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("timeout: %0d words still pending, %0d results outstanding",
                 pending_blocks.size(), expected_blocks.size());
        $display("xtea_block_cipher_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/xtea_pkg.sv
rtl/xtea_cfg_regs.sv
rtl/xtea_half_round.sv
rtl/xtea_block_cipher.sv
tb/xtea_block_cipher_tb.sv
